// ----- src/stt_pkg.sv -----
`timescale 1ns / 1ps

package stt_pkg;

   localparam int CAPACITY_DEFAULT = 8;

   typedef enum logic [1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_CANCEL = 2'd1,
      FUNC_TICK   = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      KIND_ADDED    = 3'd0,
      KIND_FULL     = 3'd1,
      KIND_REMOVED  = 3'd2,
      KIND_BAD_SLOT = 3'd3,
      KIND_FIRED    = 3'd4,
      KIND_IDLE     = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   // Action reference: the code is zero whenever the present flag is clear.
   typedef struct packed {
      logic       present;
      logic [7:0] code;
   } act_type;

   typedef struct packed {
      logic [14:0] period;
      logic [14:0] remaining;
      logic [15:0] repeats;
      act_type     action;
      act_type     alternate;
      act_type     callback;
   } entry_type;

   // Request beat layout, highest bits first.
   typedef struct packed {
      logic [2:0]  pad;
      logic [2:0]  slot;
      logic [7:0]  callback_code;
      logic        callback_present;
      logic [7:0]  alternate_code;
      logic        alternate_present;
      logic [7:0]  action_code;
      logic        action_present;
      logic [15:0] repeat_count;
      logic [14:0] period;
   } req_type;

   typedef struct packed {
      kind_type   kind;
      logic [2:0] slot;
      act_type    run;
      logic       finished;
      act_type    done;
      logic [3:0] held;
      logic       last;
   } result_type;

   typedef struct packed {
      logic load;
      logic sweep;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic cancel_ok;
      logic sweep_done;
      logic out_free;
   } dp_status_type;

   function automatic act_type pack_act(input logic present, input logic [7:0] code);
      act_type a;
      a.present = present;
      a.code    = present ? code : 8'd0;
      return a;
   endfunction

   function automatic logic [14:0] reload_of(input logic [14:0] period);
      return (period == 15'd0) ? 15'd1 : period;
   endfunction

endpackage

// ----- src/software_timer_table.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tdata: task fields, tuser: func
// rsp_      out        rsp_tvalid/rsp_tready  tdata: result fields, tuser: kind, tlast
//
// One request is taken at a time. An add, a refused add, a bad cancel or an unused
// func code goes from the load straight to its final beat. A tick sweeps the table,
// reading one table entry per cycle through the registered task memory read port
// unless a stalled result holds the sweep, and then gives the final beat. A cancel
// sweeps the slots after the removed one to shift them down; when the last slot is
// removed there is nothing to shift.
// Reset is synchronous and active high; it empties the table without touching the
// memory. A stalled result beat holds the sweep only when a newer firing needs its
// place, and the final beat of a request waits until the output register is free;
// otherwise the next request is taken while the result waits.

module software_timer_table #(
   parameter int CAPACITY = stt_pkg::CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // period[14:0], repeat_count[30:15], action_present[31], action_code[39:32],
   // alternate_present[40], alternate_code[48:41], callback_present[49],
   // callback_code[57:50], slot[60:58], zero[63:61]
   input  logic [63:0] req_tdata,
   // func[1:0]
   input  logic [1:0]  req_tuser,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // slot_out[2:0], run_valid[3], run_code[11:4], finished[12], done_valid[13],
   // done_code[21:14], tasks_held[25:22], zero[31:26]
   output logic [31:0] rsp_tdata,
   // kind[2:0]
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast
);

   stt_pkg::func_type      func;
   stt_pkg::ctrl_cmd_type  cmd;
   stt_pkg::dp_status_type status;
   stt_pkg::result_type    rsp;

   assign func = stt_pkg::func_type'(req_tuser);

   // The controller sequences each request: load, optional sweep, then the
   // final result beat.
   stt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .func      (func),
      .status    (status),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   // The datapath holds the task memory, the sweep pointers, the one-deep
   // pending result and the output register.
   stt_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .func      (func),
      .req_data  (req_tdata),
      .rsp_ready (rsp_tready),
      .status    (status),
      .rsp_valid (rsp_tvalid),
      .rsp       (rsp)
   );

   assign rsp_tdata = {6'd0, rsp.held, rsp.done.code, rsp.done.present, rsp.finished,
                       rsp.run.code, rsp.run.present, rsp.slot};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

endmodule

// ----- src/stt_ram.sv -----
`timescale 1ns / 1ps

module stt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // Read data holds while no read is issued.
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/stt_ctrl.sv -----
`timescale 1ns / 1ps

module stt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  stt_pkg::func_type        func,
   input  stt_pkg::dp_status_type   status,
   output logic                     req_ready,
   output stt_pkg::ctrl_cmd_type    cmd
);

   stt_pkg::state_type state_ff, state_in;
   logic               req_fire;

   assign req_fire = req_valid && (state_ff == stt_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stt_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (func)
                  stt_pkg::FUNC_TICK:   state_in = stt_pkg::ST_SWEEP;
                  stt_pkg::FUNC_CANCEL: state_in = status.cancel_ok ? stt_pkg::ST_SWEEP
                                                                    : stt_pkg::ST_FINISH;
                  default:              state_in = stt_pkg::ST_FINISH;
               endcase
            end
         end
         stt_pkg::ST_SWEEP: begin
            if (status.sweep_done) state_in = stt_pkg::ST_FINISH;
         end
         stt_pkg::ST_FINISH: begin
            if (status.out_free) state_in = stt_pkg::ST_IDLE;
         end
         default: state_in = stt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = (state_ff == stt_pkg::ST_IDLE);
      cmd.load   = req_fire;
      cmd.sweep  = (state_ff == stt_pkg::ST_SWEEP);
      cmd.finish = (state_ff == stt_pkg::ST_FINISH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/stt_datapath.sv -----
`timescale 1ns / 1ps

module stt_datapath #(
   parameter int CAPACITY = stt_pkg::CAPACITY_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  stt_pkg::ctrl_cmd_type  cmd,
   input  stt_pkg::func_type      func,
   input  logic [63:0]            req_data,
   input  logic                   rsp_ready,
   output stt_pkg::dp_status_type status,
   output logic                   rsp_valid,
   output stt_pkg::result_type    rsp
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int WW = (CW > 4) ? CW : 4;

   stt_pkg::req_type    req;
   stt_pkg::entry_type  entry_q, entry_upd, entry_new;
   stt_pkg::result_type fired, pend_ff, pend_in, rsp_ff, rsp_in, done_res;

   logic [CW-1:0] count_ff, count_in, old_ff, old_in, iss_ff, iss_in;
   logic [CW-1:0] wr_ff, wr_in, rd_ff, rd_in, wr_next, held_c, count_inc, count_dec;
   logic          pv_ff, pv_in, tick_ff, tick_in, pend_v_ff, pend_v_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [WW-1:0] rd_w, held_w, count_w, inc_w, dec_w, slot_w;
   logic          out_free, due, last_rep, tick_emit, block, step, issue, proc, keep;
   logic          add_ok, cancel_ok, ram_we, entry_bits_we;
   logic [IW-1:0] ram_waddr;
   logic [$bits(stt_pkg::entry_type)-1:0] ram_wdata, ram_rdata;

   assign req     = stt_pkg::req_type'(req_data);
   assign entry_q = stt_pkg::entry_type'(ram_rdata);

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign due       = (entry_q.remaining <= 15'd1);
   assign last_rep  = due && (entry_q.repeats == 16'd1);
   assign tick_emit = pv_ff && tick_ff && due;
   assign block     = tick_emit && pend_v_ff && !out_free;
   assign step      = cmd.sweep && !block;
   assign issue     = step && (iss_ff < old_ff);
   assign proc      = step && pv_ff;
   assign keep      = !(tick_ff && last_rep);

   assign count_inc = count_ff + CW'(1);
   assign count_dec = count_ff - CW'(1);
   assign wr_next   = keep ? (wr_ff + CW'(1)) : wr_ff;
   // Tasks held while sweeping: survivors so far plus entries not yet visited.
   assign held_c    = wr_next + old_ff - rd_ff - CW'(1);

   assign rd_w    = WW'(rd_ff);
   assign held_w  = WW'(held_c);
   assign count_w = WW'(count_ff);
   assign inc_w   = WW'(count_inc);
   assign dec_w   = WW'(count_dec);
   assign slot_w  = WW'(req.slot);

   assign add_ok    = (count_ff < CW'(CAPACITY));
   assign cancel_ok = (slot_w < count_w);

   always_comb begin
      entry_upd = entry_q;
      if (tick_ff) begin
         if (due) begin
            if (entry_q.repeats > 16'd1) entry_upd.repeats = entry_q.repeats - 16'd1;
            if (entry_q.alternate.present) begin
               entry_upd.action    = entry_q.alternate;
               entry_upd.alternate = entry_q.action;
            end
            entry_upd.remaining = stt_pkg::reload_of(entry_q.period);
         end else begin
            entry_upd.remaining = entry_q.remaining - 15'd1;
         end
      end
   end

   always_comb begin
      entry_new.period    = req.period;
      entry_new.remaining = stt_pkg::reload_of(req.period);
      entry_new.repeats   = req.repeat_count;
      entry_new.action    = stt_pkg::pack_act(req.action_present, req.action_code);
      entry_new.alternate = stt_pkg::pack_act(req.alternate_present, req.alternate_code);
      entry_new.callback  = stt_pkg::pack_act(req.callback_present, req.callback_code);
   end

   always_comb begin
      fired          = '0;
      fired.kind     = stt_pkg::KIND_FIRED;
      fired.slot     = rd_w[2:0];
      fired.run      = entry_q.action;
      fired.finished = last_rep;
      fired.done     = last_rep ? entry_q.callback : '0;
      fired.held     = held_w[3:0];
   end

   always_comb begin
      done_res = '0;
      if (pend_v_ff) begin
         done_res = pend_ff;
      end else begin
         done_res.kind = stt_pkg::KIND_IDLE;
         done_res.held = count_w[3:0];
      end
      done_res.last = 1'b1;
   end

   assign entry_bits_we = cmd.load && (func == stt_pkg::FUNC_ADD) && add_ok;
   assign ram_we        = entry_bits_we || (proc && keep);
   assign ram_waddr     = entry_bits_we ? count_ff[IW-1:0] : wr_ff[IW-1:0];
   assign ram_wdata     = entry_bits_we ? entry_new : entry_upd;

   stt_ram #(
      .WIDTH ($bits(stt_pkg::entry_type)),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (issue),
      .rd_addr (iss_ff[IW-1:0]),
      .rd_data (ram_rdata)
   );

   always_comb begin
      count_in     = count_ff;
      old_in       = old_ff;
      iss_in       = iss_ff;
      wr_in        = wr_ff;
      rd_in        = rd_ff;
      pv_in        = pv_ff;
      tick_in      = tick_ff;
      pend_v_in    = pend_v_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.load) begin
         pend_in = '0;
         case (func)
            stt_pkg::FUNC_ADD: begin
               pend_v_in = 1'b1;
               if (add_ok) begin
                  count_in     = count_inc;
                  pend_in.kind = stt_pkg::KIND_ADDED;
                  pend_in.slot = count_w[2:0];
                  pend_in.held = inc_w[3:0];
               end else begin
                  pend_in.kind = stt_pkg::KIND_FULL;
                  pend_in.held = count_w[3:0];
               end
            end
            stt_pkg::FUNC_CANCEL: begin
               pend_v_in    = 1'b1;
               pend_in.slot = req.slot;
               if (cancel_ok) begin
                  count_in     = count_dec;
                  old_in       = count_ff;
                  iss_in       = slot_w[CW-1:0] + CW'(1);
                  wr_in        = slot_w[CW-1:0];
                  tick_in      = 1'b0;
                  pv_in        = 1'b0;
                  pend_in.kind = stt_pkg::KIND_REMOVED;
                  pend_in.held = dec_w[3:0];
               end else begin
                  pend_in.kind = stt_pkg::KIND_BAD_SLOT;
                  pend_in.held = count_w[3:0];
               end
            end
            stt_pkg::FUNC_TICK: begin
               pend_v_in = 1'b0;
               old_in    = count_ff;
               iss_in    = '0;
               wr_in     = '0;
               tick_in   = 1'b1;
               pv_in     = 1'b0;
            end
            default: begin
               pend_v_in = 1'b0;
            end
         endcase
      end

      if (step) begin
         pv_in = issue;
         if (issue) begin
            iss_in = iss_ff + CW'(1);
            rd_in  = iss_ff;
         end
         if (proc) begin
            wr_in = wr_next;
            if (tick_ff) count_in = held_c;
            if (tick_emit) begin
               pend_in   = fired;
               pend_v_in = 1'b1;
               // The held result is known not to be the final one now.
               if (pend_v_ff) begin
                  rsp_in       = pend_ff;
                  rsp_valid_in = 1'b1;
               end
            end
         end
      end

      if (cmd.finish && out_free) begin
         rsp_in       = done_res;
         rsp_valid_in = 1'b1;
         pend_v_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         old_ff       <= '0;
         iss_ff       <= '0;
         wr_ff        <= '0;
         rd_ff        <= '0;
         pv_ff        <= 1'b0;
         tick_ff      <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         old_ff       <= old_in;
         iss_ff       <= iss_in;
         wr_ff        <= wr_in;
         rd_ff        <= rd_in;
         pv_ff        <= pv_in;
         tick_ff      <= tick_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      status.cancel_ok  = cancel_ok;
      status.sweep_done = !pv_ff && (iss_ff >= old_ff);
      status.out_free   = out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- src/stt_checker.sv -----
`timescale 1ns / 1ps

module stt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // A result beat that is not taken stays offered with the same tdata.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // Reset leaves no result beat on offer.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat offered after reset");

   // Requests are worked one at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in work");

   // Only a tick can cause several beats, and those are all firings.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser == stt_pkg::KIND_FIRED)
      else $error("non-final beat is not a firing");

   // The task count never exceeds 8 and the kind never lies beyond the idle code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[25:22] <= 4'd8 && rsp_tuser <= stt_pkg::KIND_IDLE)
      else $error("result kind or task count out of range");

endmodule

bind software_timer_table stt_checker u_stt_checker (.*);
